### rtl/tbsa_pkg.sv
// Shared constants, types and reset-value functions of the tree bitmap slot allocator.
`timescale 1ns / 1ps

package tbsa_pkg;

    // Pool size and the tree geometry that follows from it.
    localparam int SLOTS    = 64;
    localparam int LEVELS   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LEAVES   = 1 << LEVELS;
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    // Field widths of the words on the two channels.
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Operation codes carried on the input tuser.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes carried on the output tuser.
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DOWN,
        S_UP,
        S_FREE,
        S_OUT
    } state_t;

    // One result word as it leaves the tree walker.
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } result_t;

    // A node is full after reset when its first leaf lies beyond the pool,
    // i.e. it covers padding leaves only.
    function automatic logic node_reset_full(input logic [LEVELS:0] node);
        logic [LEVELS:0] x;
        x = node;
        for (int i = 0; i < LEVELS; i++) begin
            if (!x[LEVELS]) begin
                x = x << 1;
            end
        end
        return ({1'b0, x[LEVELS-1:0]} >= (LEVELS+1)'(SLOTS));
    endfunction

    // Reset contents of the pair entry that holds the marks of the two
    // children of a parent node: bit 0 left child, bit 1 right child.
    function automatic logic [1:0] pair_reset(input logic [LEVELS-1:0] parent);
        return {node_reset_full({parent, 1'b1}), node_reset_full({parent, 1'b0})};
    endfunction

endpackage

### rtl/tbsa_pair_mem.sv
// Synchronous memory of child-pair full marks with per-entry valid bits.
`timescale 1ns / 1ps

module tbsa_pair_mem (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [tbsa_pkg::LEVELS-1:0] wr_addr,
    input  logic [1:0]                 wr_data,
    input  logic [tbsa_pkg::LEVELS-1:0] rd_addr,
    output logic [1:0]                 rd_data
);

    localparam int DEPTH = tbsa_pkg::LEAVES / 2 * 2;

    logic [1:0]                  mem [DEPTH];
    logic [DEPTH-1:0]            valid_reg;
    logic [1:0]                  mem_q_reg;
    logic                        valid_q_reg;
    logic [tbsa_pkg::LEVELS-1:0] addr_q_reg;

    // Storage array: one write and one registered read each cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg  <= mem[rd_addr];
        addr_q_reg <= rd_addr;
    end

    // Valid bits: an entry never written reads as its reset contents.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            valid_q_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            valid_q_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = valid_q_reg ? mem_q_reg : tbsa_pkg::pair_reset(addr_q_reg);

endmodule

### rtl/tbsa_walker.sv
// Tree walker: descends and then climbs back for allocate, climbs for free, and keeps the pool count.
`timescale 1ns / 1ps

module tbsa_walker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           in_op,
    input  logic [tbsa_pkg::SLOT_W-1:0]    in_slot,
    output logic                           res_valid,
    input  logic                           res_ready,
    output tbsa_pkg::result_t              res,
    output logic                           mem_wr_en,
    output logic [tbsa_pkg::LEVELS-1:0]    mem_wr_addr,
    output logic [1:0]                     mem_wr_data,
    output logic [tbsa_pkg::LEVELS-1:0]    mem_rd_addr,
    input  logic [1:0]                     mem_rd_data
);

    localparam int LV = tbsa_pkg::LEVELS;

    tbsa_pkg::state_t               state_reg, state_next;
    logic [LV:0]                    cur_reg, cur_next;
    logic [tbsa_pkg::LVL_W-1:0]     lvl_reg, lvl_next;
    logic [1:0]                     path_reg [LV];
    logic                           path_we;
    logic                           first_reg, first_next;
    logic                           child_full_reg, child_full_next;
    logic                           root_full_reg, root_full_next;
    logic [tbsa_pkg::COUNT_W-1:0]   count_reg, count_next;
    tbsa_pkg::result_t              res_reg, res_next;

    logic                           accept;
    logic [LV:0]                    leaf_node;
    logic [LV:0]                    child;
    logic [LV-1:0]                  parent;
    logic [1:0]                     pair;
    logic                           last_level;
    logic                           slot_oob;

    assign accept     = in_valid && (state_reg == tbsa_pkg::S_IDLE);
    assign leaf_node  = {1'b1, in_slot[LV-1:0]};
    assign child      = {cur_reg[LV-1:0], mem_rd_data[0]};
    assign parent     = cur_reg[LV:1];
    assign last_level = (lvl_reg == tbsa_pkg::LVL_W'(LV - 1));
    assign slot_oob   = ({1'b0, in_slot} >= (tbsa_pkg::SLOT_W+1)'(tbsa_pkg::SLOTS));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tbsa_pkg::S_IDLE: begin
                if (accept) begin
                    if (in_op == tbsa_pkg::OP_ALLOC) begin
                        state_next = root_full_reg ? tbsa_pkg::S_OUT : tbsa_pkg::S_DOWN;
                    end else begin
                        state_next = slot_oob ? tbsa_pkg::S_OUT : tbsa_pkg::S_FREE;
                    end
                end
            end
            tbsa_pkg::S_DOWN: begin
                if (last_level) begin
                    state_next = tbsa_pkg::S_UP;
                end
            end
            tbsa_pkg::S_UP: begin
                if (parent == LV'(1)) begin
                    state_next = tbsa_pkg::S_OUT;
                end
            end
            tbsa_pkg::S_FREE: begin
                if ((first_reg && !mem_rd_data[cur_reg[0]]) || parent == LV'(1)) begin
                    state_next = tbsa_pkg::S_OUT;
                end
            end
            tbsa_pkg::S_OUT: begin
                if (res_ready) begin
                    state_next = tbsa_pkg::S_IDLE;
                end
            end
            default: state_next = tbsa_pkg::S_IDLE;
        endcase
    end

    // Datapath, memory controls and handshake outputs.
    always_comb begin
        cur_next        = cur_reg;
        lvl_next        = lvl_reg;
        first_next      = first_reg;
        child_full_next = child_full_reg;
        root_full_next  = root_full_reg;
        count_next      = count_reg;
        res_next        = res_reg;
        path_we         = 1'b0;
        pair            = path_reg[lvl_reg];
        mem_wr_en       = 1'b0;
        mem_wr_addr     = parent;
        mem_wr_data     = pair;
        mem_rd_addr     = LV'(1);
        in_ready        = (state_reg == tbsa_pkg::S_IDLE);
        res_valid       = (state_reg == tbsa_pkg::S_OUT);
        unique case (state_reg)
            tbsa_pkg::S_IDLE: begin
                lvl_next        = '0;
                first_next      = 1'b1;
                child_full_next = 1'b1;
                res_next.count  = count_reg;
                res_next.status = tbsa_pkg::ST_DONE;
                if (in_op == tbsa_pkg::OP_ALLOC) begin
                    // Start the descent at the root pair.
                    cur_next     = (LV+1)'(1);
                    mem_rd_addr  = LV'(1);
                    res_next.slot = '0;
                    if (root_full_reg) begin
                        res_next.status = tbsa_pkg::ST_FULL;
                    end
                end else begin
                    // Read the pair that holds the leaf being freed.
                    cur_next      = leaf_node;
                    mem_rd_addr   = leaf_node[LV:1];
                    res_next.slot = in_slot;
                    if (slot_oob) begin
                        res_next.status = tbsa_pkg::ST_NOT_USED;
                    end
                end
            end
            tbsa_pkg::S_DOWN: begin
                // Go left unless the left child is full; remember the pair.
                path_we     = 1'b1;
                cur_next    = child;
                mem_rd_addr = child[LV-1:0];
                if (last_level) begin
                    res_next.slot = tbsa_pkg::SLOT_W'(child[LV-1:0]);
                end else begin
                    lvl_next = lvl_reg + tbsa_pkg::LVL_W'(1);
                end
            end
            tbsa_pkg::S_UP: begin
                // Write back the path pair with the child's new mark.
                pair[cur_reg[0]] = child_full_reg;
                mem_wr_en        = 1'b1;
                mem_wr_data      = pair;
                child_full_next  = &pair;
                cur_next         = {1'b0, parent};
                if (parent == LV'(1)) begin
                    root_full_next = &pair;
                    count_next     = count_reg + tbsa_pkg::COUNT_W'(1);
                    res_next.count = count_reg + tbsa_pkg::COUNT_W'(1);
                end else begin
                    lvl_next = lvl_reg - tbsa_pkg::LVL_W'(1);
                end
            end
            tbsa_pkg::S_FREE: begin
                // Clear the mark of the current node in its parent's pair.
                pair            = mem_rd_data;
                pair[cur_reg[0]] = 1'b0;
                first_next      = 1'b0;
                mem_rd_addr     = LV'(parent >> 1);
                if (first_reg && !mem_rd_data[cur_reg[0]]) begin
                    res_next.status = tbsa_pkg::ST_NOT_USED;
                end else begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = pair;
                    cur_next    = {1'b0, parent};
                    if (parent == LV'(1)) begin
                        root_full_next = 1'b0;
                        if (count_reg != '0) begin
                            count_next     = count_reg - tbsa_pkg::COUNT_W'(1);
                            res_next.count = count_reg - tbsa_pkg::COUNT_W'(1);
                        end
                    end
                end
            end
            tbsa_pkg::S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tbsa_pkg::S_IDLE;
            root_full_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            root_full_reg <= root_full_next;
            count_reg     <= count_next;
        end
    end

    // Walk registers and the per-level pair record.
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        lvl_reg        <= lvl_next;
        first_reg      <= first_next;
        child_full_reg <= child_full_next;
        res_reg        <= res_next;
        if (path_we) begin
            path_reg[lvl_reg] <= mem_rd_data;
        end
    end

    assign res = res_reg;

endmodule

### rtl/tree_bitmap_slot_allocator.sv
// Top level of the tree bitmap slot allocator: walker, mark memory and output register.
`timescale 1ns / 1ps

// Grants the lowest free slot of a pool of 64 and frees given slots, keeping a binary
// tree of full marks in a single-port-read, single-port-write synchronous memory of
// child pairs. One word is worked at a time. An allocate walks down one tree level per
// cycle and then writes the marks back one level per cycle before its result is
// offered. A free reads and rewrites one ancestor pair per cycle, from the leaf up to
// the root pair. A refused allocate on a full pool or a free beyond the pool goes
// straight to its result without walking the tree, and a free of a slot that is not
// in use is refused once its leaf pair has been read. A finished result is held in the
// walker until the output register is empty or being drained. A finished result waits
// in an output register, so the next word is taken while it is still unclaimed. After
// reset every slot is free; no clearing pass is needed.
module tree_bitmap_slot_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] slot_in, [7:6] zero
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] slot_out, [12:6] in_use_count, [15:13] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic                          res_valid;
    logic                          res_ready;
    tbsa_pkg::result_t             res;
    logic                          mem_wr_en;
    logic [tbsa_pkg::LEVELS-1:0]   mem_wr_addr;
    logic [1:0]                    mem_wr_data;
    logic [tbsa_pkg::LEVELS-1:0]   mem_rd_addr;
    logic [1:0]                    mem_rd_data;

    logic                          m_tvalid_reg, m_tvalid_next;
    tbsa_pkg::result_t             out_reg, out_next;

    tbsa_walker u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser[0]),
        .in_slot     (s_tdata[tbsa_pkg::SLOT_W-1:0]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tbsa_pair_mem u_pair_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output register: loads a finished result whenever it is empty or being drained.
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_reg.count, out_reg.slot};
    assign m_tuser  = out_reg.status;

endmodule

### dv/tree_bitmap_slot_allocator_tb.sv
// Self-checking testbench for the tree bitmap slot allocator, with its own tree predictor.
`timescale 1ns / 1ps

module tree_bitmap_slot_allocator_tb;

    import tbsa_pkg::*;

    // Cycles with no word accepted on either channel before the run is abandoned.
    localparam int STALL_LIMIT = 20000;
    // Length of the long receiver hold-off used to back the block up.
    localparam int HOLD_CYCLES = 300;

    // One expected result word.
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } grant_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [5:0] slot_in, [7:6] zero
    logic [0:0]  s_tuser  = '0;   // [0] op
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [5:0] slot_out, [12:6] in_use_count, [15:13] zero
    logic [1:0]  m_tuser;         // [1:0] status

    // Predictor state: heap-ordered full marks (node 1 is the root) and the slot count.
    logic [2*LEAVES-1:0] full_mark = '0;
    int unsigned         slots_used = 0;

    grant_t pending_grants[$];
    int     mismatches   = 0;
    int     stall_cycles = 0;
    int     tx_idle_pct  = 0;
    int     rx_idle_pct  = 0;
    logic   rx_hold      = 1'b0;
    event   start_hold;

    tree_bitmap_slot_allocator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Applies one word to the predicted tree and returns the result it should give.
    function automatic grant_t predict_grant(input logic op, input logic [SLOT_W-1:0] slot);
        grant_t r;
        int     n;
        r.slot   = '0;
        r.status = ST_DONE;
        if (op == OP_ALLOC) begin
            if (full_mark[1]) begin
                r.status = ST_FULL;
            end else begin
                // Walk down, preferring the left child while it still has room.
                n = 1;
                while (n < LEAVES) begin
                    n = full_mark[2*n] ? 2*n + 1 : 2*n;
                end
                r.slot = SLOT_W'(n - LEAVES);
                full_mark[n] = 1'b1;
                while (n > 1) begin
                    n = n >> 1;
                    full_mark[n] = full_mark[2*n] & full_mark[2*n+1];
                end
                slots_used++;
            end
        end else begin
            r.slot = slot;
            if (!full_mark[LEAVES + slot]) begin
                r.status = ST_NOT_USED;
            end else begin
                // No ancestor of a freed leaf can be full any more.
                n = LEAVES + slot;
                full_mark[n] = 1'b0;
                while (n > 1) begin
                    n = n >> 1;
                    full_mark[n] = 1'b0;
                end
                if (slots_used > 0) slots_used--;
            end
        end
        r.count = COUNT_W'(slots_used);
        return r;
    endfunction

    // Picks a slot that is currently allocated, or any slot when the pool is empty.
    function automatic logic [SLOT_W-1:0] pick_used_slot();
        int unsigned start;
        int unsigned s;
        start = $urandom_range(SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            s = (start + k) % SLOTS;
            if (full_mark[LEAVES + s]) return SLOT_W'(s);
        end
        return SLOT_W'(start);
    endfunction

    // Offers one word after a random gap and waits for it to be taken.
    task automatic send_word(input logic op, input logic [SLOT_W-1:0] slot);
        int unsigned gap;
        gap = 0;
        if (tx_idle_pct > 0) begin
            while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, slot};
        do @(posedge aclk); while (!s_tready);
        pending_grants.push_back(predict_grant(op, slot));
    endtask

    // Lowers valid and waits until every predicted result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_grants.size() != 0) @(posedge aclk);
    endtask

    // Result checker and receiver back-pressure.
    always @(posedge aclk) begin
        grant_t want;
        if (m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual slot %0d status %0d count %0d",
                         $time, m_tdata[5:0], m_tuser, m_tdata[12:6]);
                mismatches++;
            end else begin
                want = pending_grants.pop_front();
                if (m_tdata[5:0] !== want.slot) begin
                    $display("%0t: slot_out mismatch, expected %0d actual %0d",
                             $time, want.slot, m_tdata[5:0]);
                    mismatches++;
                end
                if (m_tuser !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, m_tuser);
                    mismatches++;
                end
                if (m_tdata[12:6] !== want.count) begin
                    $display("%0t: in_use_count mismatch, expected %0d actual %0d",
                             $time, want.count, m_tdata[12:6]);
                    mismatches++;
                end
            end
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off, counted here so the sender can keep pushing meanwhile.
    initial begin
        forever begin
            @(start_hold);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge aclk);
            rx_hold <= 1'b0;
        end
    end

    // Count cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Frees on an empty pool, grants of the lowest slot, double frees and refills.
    task automatic test_directed();
        send_word(OP_FREE,  6'd0);
        send_word(OP_FREE,  6'd63);
        send_word(OP_ALLOC, 6'd63);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_ALLOC, 6'd21);
        send_word(OP_ALLOC, 6'd42);
        send_word(OP_FREE,  6'd1);
        send_word(OP_FREE,  6'd1);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_FREE,  6'd0);
        send_word(OP_FREE,  6'd2);
        send_word(OP_ALLOC, 6'd63);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_FREE,  6'd63);
        send_word(OP_FREE,  6'd32);
        send_word(OP_FREE,  6'd3);
        send_word(OP_FREE,  6'd0);
        send_word(OP_FREE,  6'd1);
        send_word(OP_FREE,  6'd2);
        send_word(OP_ALLOC, 6'd0);
        drain();
    endtask

    // Fill the pool, hit the full refusal, then punch holes at both ends and in the middle and refill.
    task automatic test_pool_full();
        while (slots_used < SLOTS) send_word(OP_ALLOC, 6'($urandom_range(63)));
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_ALLOC, 6'd63);
        send_word(OP_FREE,  6'd63);
        send_word(OP_FREE,  6'd0);
        send_word(OP_FREE,  6'd31);
        send_word(OP_FREE,  6'd32);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_ALLOC, 6'd0);
        send_word(OP_FREE,  6'd63);
        drain();
    endtask

    // Random traffic whose allocate share shifts so the pool sweeps empty to full.
    task automatic test_random(input int n_words, input int tx_pct, input int rx_pct);
        int          alloc_pct;
        logic        op;
        logic [SLOT_W-1:0] slot;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        alloc_pct   = 50;
        for (int i = 0; i < n_words; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(2))
                    0: alloc_pct = 15;
                    1: alloc_pct = 50;
                    default: alloc_pct = 85;
                endcase
            end
            op = ($urandom_range(99) < alloc_pct) ? OP_ALLOC : OP_FREE;
            if (op == OP_FREE && $urandom_range(99) < 75) begin
                slot = pick_used_slot();
            end else begin
                slot = 6'($urandom_range(63));
            end
            send_word(op, slot);
        end
        drain();
    endtask

    // Receiver stops for a long stretch while the sender keeps offering words.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        -> start_hold;
        for (int i = 0; i < 40; i++) begin
            if (i % 2 == 0) begin
                send_word(OP_ALLOC, 6'($urandom_range(63)));
            end else begin
                send_word(OP_FREE, pick_used_slot());
            end
        end
        drain();
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 21;
        rx_idle_pct = 81;
        test_directed();
        test_pool_full();
        test_random(570, 21, 81);
        test_random(570, 81, 21);
        test_random(570, 0, 0);
        test_backpressure();

        // Let any late word show up before the verdict.
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && pending_grants.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
